// ===== rtl/core/bfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator: the request
// and response beats, operation codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Bitmap word geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned LOG_WB    = 5;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LEN_W     = 33;

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_FREE      = 3'd1,
    OP_TEST      = 3'd2,
    OP_MARK_FREE = 3'd3,
    OP_MARK_USED = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic              found;
    logic              frame_used;
    logic              out_of_range;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr;   // write an all-used word and advance
    logic load;  // capture a request
    logic rd;    // read the word at the pointer
    logic eval;  // evaluate the read word, write back
    logic adv;   // advance to the next word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty; // no frame in the span
    logic last;  // pointer is on the last word of the span
    logic stop;  // item finished early (allocate hit or test)
  } sts_t;

endpackage

// ===== rtl/core/bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit bitmap allocator of physical frames, one used bit per frame.
// ----------------------------------------------------------------------------
// After reset the block sweeps its bitmap RAM to all-used, one 32-frame word
// a cycle (ceil(FRAME_COUNT/32) words, 2048 by default), with busy high.
// An item is taken when start is high and busy low; its result beat comes on
// rsp_o with done_o high for one cycle and must be taken then, since there is
// no back-pressure. Each item checks its span, then does one RAM read and one
// evaluate and write-back per bitmap word it visits: free and test touch one
// word, mark range touches every word of its span, and allocate scans from
// word 0 up to the first word with a free frame below the frame count.
// The user must write the frame count register through cfg_we_i only while
// busy is low; it is not enforced. FRAME_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int unsigned FRAME_BYTES = 4096,
  parameter int unsigned FRAME_COUNT = 65536
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      start,
  output logic                      busy,
  input  bfa_pkg::req_t             req_i,
  output logic                      done_o,
  output bfa_pkg::rsp_t             rsp_o
);

  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;

  // Sequence the work
  bfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // Hold the bitmap and results
  bfa_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

endmodule

// ===== rtl/core/bfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Controller: clearing pass after reset, then per item a check of the span,
// a read/evaluate loop over any bitmap words of the span and one response beat.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bfa_pkg::sts_t sts_i,
  output bfa_pkg::cmd_t cmd_o,
  output logic          busy,
  output logic          done_o
);

  bfa_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      bfa_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.last) begin
          state_d = bfa_pkg::ST_IDLE;
        end
      end
      bfa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = bfa_pkg::ST_CHECK;
        end
      end
      bfa_pkg::ST_CHECK: begin
        state_d = sts_i.empty ? bfa_pkg::ST_RESP : bfa_pkg::ST_READ;
      end
      bfa_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = bfa_pkg::ST_EVAL;
      end
      bfa_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.stop || sts_i.last) begin
          state_d = bfa_pkg::ST_RESP;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = bfa_pkg::ST_READ;
        end
      end
      bfa_pkg::ST_RESP: begin
        done_o  = 1'b1;
        state_d = bfa_pkg::ST_IDLE;
      end
      default: begin
        state_d = bfa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bfa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: frame count register, span bounds, word pointer, bitmap RAM,
// masked read-modify-write of one word and the result registers.
// ----------------------------------------------------------------------------
module bfa_dp #(
  parameter int unsigned FRAME_BYTES = 4096,
  parameter int unsigned FRAME_COUNT = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfa_pkg::CFG_W-1:0]   cfg_data_i,
  input  bfa_pkg::req_t               req_i,
  input  bfa_pkg::cmd_t               cmd_i,
  output bfa_pkg::sts_t               sts_o,
  output bfa_pkg::rsp_t               rsp_o
);

  localparam int unsigned WB    = bfa_pkg::WORD_BITS;
  localparam int unsigned LWB   = bfa_pkg::LOG_WB;
  localparam int unsigned SHIFT = $clog2(FRAME_BYTES);
  localparam int unsigned DEPTH = (FRAME_COUNT + WB - 1) / WB;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = $clog2(FRAME_COUNT + WB);
  localparam int unsigned XW    = bfa_pkg::LEN_W + 1;
  localparam logic [XW-1:0] FC_X    = XW'(FRAME_COUNT);
  localparam logic [XW-1:0] SPACE_X = XW'(64'h1_0000_0000);

  logic [bfa_pkg::CFG_W-1:0] cfg_q;
  logic [2:0]                op_q;
  logic [IW-1:0]             lo_q, lo_d, hi_q, hi_d, base_q, base_d;
  logic                      oor_d;
  logic [bfa_pkg::ADDR_W-1:0] fa_q;
  logic                      found_q, used_q, oor_q;

  logic [XW-1:0]  sf_x, ef_x, end_x, lim_x, sum_x;
  logic [IW:0]    next_base;
  logic [WB-1:0]  rdata, mask, free_v, wdata;
  logic [LWB-1:0] pos;
  logic [IW-1:0]  hit_idx;
  logic [63:0]    fa_wide;
  logic           hit, we;

  // Hold the frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Work out the span of frames for the request
  always_comb begin
    sum_x = XW'(req_i.address) + XW'(req_i.length);
    end_x = (sum_x > SPACE_X) ? SPACE_X : sum_x;
    sf_x  = XW'(req_i.address) >> SHIFT;
    ef_x  = end_x >> SHIFT;
    lim_x = (XW'(cfg_q) > FC_X) ? FC_X : XW'(cfg_q);
    lo_d  = '0;
    hi_d  = '0;
    oor_d = 1'b0;
    case (req_i.operation)
      bfa_pkg::OP_ALLOC: begin
        hi_d = IW'(lim_x);
      end
      bfa_pkg::OP_FREE, bfa_pkg::OP_TEST: begin
        oor_d = (sf_x >= FC_X);
        if (!oor_d) begin
          lo_d = IW'(sf_x);
          hi_d = IW'(sf_x + XW'(1));
        end
      end
      bfa_pkg::OP_MARK_FREE, bfa_pkg::OP_MARK_USED: begin
        oor_d = (ef_x > sf_x) && (ef_x > FC_X);
        lo_d  = (sf_x > FC_X) ? IW'(FC_X) : IW'(sf_x);
        hi_d  = (ef_x > FC_X) ? IW'(FC_X) : IW'(ef_x);
      end
      default: begin
        lo_d = '0;
      end
    endcase
  end

  // Mask the word to the span and find the lowest free frame
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      hit_idx = {base_q[IW-1:LWB], LWB'(b)};
      mask[b] = (hit_idx >= lo_q) && (hit_idx < hi_q);
    end
    free_v = ~rdata & mask;
    hit    = |free_v;
    pos    = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (free_v[b]) begin
        pos = LWB'(b);
      end
    end
    hit_idx = {base_q[IW-1:LWB], pos};
    fa_wide = 64'(hit_idx) << SHIFT;
    case (op_q)
      bfa_pkg::OP_ALLOC: begin
        wdata = rdata | (WB'(1) << pos);
        we    = hit;
      end
      bfa_pkg::OP_MARK_USED: begin
        wdata = rdata | mask;
        we    = 1'b1;
      end
      bfa_pkg::OP_FREE, bfa_pkg::OP_MARK_FREE: begin
        wdata = rdata & ~mask;
        we    = 1'b1;
      end
      default: begin
        wdata = rdata;
        we    = 1'b0;
      end
    endcase
  end

  // Advance the word pointer; load a request
  assign next_base = (IW + 1)'(base_q) + (IW + 1)'(WB);
  always_comb begin
    base_d = base_q;
    if (cmd_i.load) begin
      base_d = {lo_d[IW-1:LWB], LWB'(0)};
    end else if (cmd_i.clr || cmd_i.adv) begin
      base_d = next_base[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      lo_q   <= '0;
      hi_q   <= IW'(FRAME_COUNT);
      op_q   <= '0;
    end else begin
      base_q <= base_d;
      if (cmd_i.load) begin
        lo_q <= lo_d;
        hi_q <= hi_d;
        op_q <= req_i.operation;
      end
    end
  end

  // Capture the results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fa_q    <= '0;
      found_q <= 1'b0;
      used_q  <= 1'b0;
      oor_q   <= oor_d;
    end else if (cmd_i.eval) begin
      if (op_q == bfa_pkg::OP_ALLOC && hit) begin
        fa_q    <= fa_wide[bfa_pkg::ADDR_W-1:0];
        found_q <= 1'b1;
      end
      if (op_q == bfa_pkg::OP_TEST) begin
        used_q <= |(rdata & mask);
      end
    end
  end

  // Bitmap store
  bfa_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr || (cmd_i.eval && we)),
    .re_i    (cmd_i.rd),
    .addr_i  (base_q[AW+LWB-1:LWB]),
    .wdata_i (cmd_i.clr ? {WB{1'b1}} : wdata),
    .rdata_o (rdata)
  );

  assign sts_o.empty = (lo_q >= hi_q);
  assign sts_o.last  = (next_base >= (IW + 1)'(hi_q));
  assign sts_o.stop  = (op_q == bfa_pkg::OP_TEST) || (op_q == bfa_pkg::OP_ALLOC && hit);

  assign rsp_o.frame_address = fa_q;
  assign rsp_o.found         = found_q;
  assign rsp_o.frame_used    = used_q;
  assign rsp_o.out_of_range  = oor_q;

endmodule
